FILE: hw/rtl/running_linear_regression_top_assert.svh
// ----------------------------------------------------------------------------
// running_linear_regression_top_assert.svh
// Assertion macros for the line fit block.
// ----------------------------------------------------------------------------
`ifndef RUNNING_LINEAR_REGRESSION_TOP_ASSERT_SVH
`define RUNNING_LINEAR_REGRESSION_TOP_ASSERT_SVH

// same-cycle implication
`define RLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rlr_pkg.sv
// ----------------------------------------------------------------------------
// rlr_pkg
// Types and constants of the running least-squares line fit.
// ----------------------------------------------------------------------------
package rlr_pkg;

  localparam int MAX_SAMPLES_DEF = 65535;
  localparam int DATA_BITS_DEF   = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COUNT_W  = 16;
  localparam int SPREAD_W = 62;
  localparam int ACC_W    = 64;
  localparam int FIT_W    = 32;

  localparam logic [FIT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [FIT_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_ACC, S_SETUP, S_DIV, S_ROUND, S_DONE
  } state_t;

  // multiply-accumulate program steps, in order
  typedef enum logic [3:0] {
    OP_XX, OP_XY, OP_D_LO, OP_D_HI, OP_D_SQ, OP_N_LO, OP_N_HI, OP_N_SQ, OP_T
  } op_t;

endpackage

FILE: hw/rtl/running_linear_regression_top.sv
// ----------------------------------------------------------------------------
// running_linear_regression_top
// Running least-squares line fit over (x, y) sample pairs.
// ----------------------------------------------------------------------------
// Each input word adds a sample (tuser = 0) or clears the set (tuser = 1) and
// yields one result word with the count, the fit flag, slope a and intercept
// b (both Q16-style with FRAC_BITS fraction bits, rounded, saturated). All
// math runs through one 33x33 multiplier, one 64-bit add/subtract unit and a
// restoring divider that retires one quotient bit per cycle. An add word runs
// the sample products, the spread and numerator terms and two divisions (slope,
// then intercept) before the next accept; the two divisions dominate. A clear
// word or a dropped word skips the two sample products. A word whose fit is
// not valid skips the divisions.
// s_tready is high only between words; a result held in the output register
// does not block the next input word.
`include "running_linear_regression_top_assert.svh"

module running_linear_regression_top #(
  parameter int MAX_SAMPLES = rlr_pkg::MAX_SAMPLES_DEF,
  parameter int DATA_BITS   = rlr_pkg::DATA_BITS_DEF,
  parameter int FRAC_BITS   = rlr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // x_sample[15:0], y_sample[31:16]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // sample_count[15:0], fit_valid[16], slope[48:17],
                                 // intercept[80:49], count_full[81], zero[87:82]
  input  logic        min_spread_we,
  input  logic [61:0] min_spread_wdata
);

  localparam int DIV_W  = 32 + FRAC_BITS;
  localparam int ITER_W = $clog2(DIV_W + 1);

  rlr_pkg::state_t state, state_next;
  rlr_pkg::op_t    op;

  logic [rlr_pkg::COUNT_W-1:0]  count;
  logic signed [31:0]           sum_x, sum_y;
  logic [46:0]                  sum_xx;
  logic signed [47:0]           sum_xy;
  logic [rlr_pkg::SPREAD_W-1:0] min_spread;

  logic signed [15:0] x_in, y_in, x_reg, y_reg;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [63:0] acc, d_reg, sy_wide;
  logic [63:0]        p_term, add_a, add_b, rem, rem_sh, den, num_mag, d_mag, den_sel;
  logic               add_sub;
  logic [64:0]        add_res;
  logic [DIV_W-1:0]   shreg, quo;
  logic [DIV_W:0]     q_round;
  logic [ITER_W-1:0]  iter;
  logic               frac_mode, neg, ovf, fit_valid, full_flag;
  logic               spread_ok, ovf_now, round_up, big, out_free, accept;
  logic signed [31:0] slope, icpt;
  logic [31:0]        div_res;

  assign x_in    = 16'($signed(s_tdata[DATA_BITS-1:0]));
  assign y_in    = 16'($signed(s_tdata[16 +: DATA_BITS]));
  assign accept  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign sy_wide = 64'(sum_y);

  // multiplier operands per program step
  always_comb begin
    mul_a = 33'(x_reg);
    mul_b = 33'(x_reg);
    case (op)
      rlr_pkg::OP_XX: begin
        mul_a = 33'(x_reg);
        mul_b = 33'(x_reg);
      end
      rlr_pkg::OP_XY: begin
        mul_a = 33'(x_reg);
        mul_b = 33'(y_reg);
      end
      rlr_pkg::OP_D_LO: begin
        mul_a = $signed({17'b0, count});
        mul_b = $signed({9'b0, sum_xx[23:0]});
      end
      rlr_pkg::OP_D_HI: begin
        mul_a = $signed({17'b0, count});
        mul_b = $signed({10'b0, sum_xx[46:24]});
      end
      rlr_pkg::OP_D_SQ: begin
        mul_a = 33'(sum_x);
        mul_b = 33'(sum_x);
      end
      rlr_pkg::OP_N_LO: begin
        mul_a = $signed({17'b0, count});
        mul_b = $signed({9'b0, sum_xy[23:0]});
      end
      rlr_pkg::OP_N_HI: begin
        mul_a = $signed({17'b0, count});
        mul_b = 33'($signed(sum_xy[47:24]));
      end
      rlr_pkg::OP_N_SQ: begin
        mul_a = 33'(sum_x);
        mul_b = 33'(sum_y);
      end
      rlr_pkg::OP_T: begin
        mul_a = 33'(slope);
        mul_b = 33'(sum_x);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared add/subtract unit: accumulation and divider trial subtract
  assign rem_sh = {rem[62:0], shreg[DIV_W-1]};
  assign p_term = (op == rlr_pkg::OP_D_HI || op == rlr_pkg::OP_N_HI) ?
                  {prod[39:0], 24'b0} : prod[63:0];

  always_comb begin
    add_a   = acc;
    add_b   = p_term;
    add_sub = 1'b0;
    if (state == rlr_pkg::S_DIV) begin
      add_a   = rem_sh;
      add_b   = den;
      add_sub = 1'b1;
    end else begin
      if (op == rlr_pkg::OP_T) begin
        add_a = sy_wide <<< FRAC_BITS;
      end else if (op == rlr_pkg::OP_D_LO || op == rlr_pkg::OP_N_LO) begin
        add_a = '0;
      end
      add_sub = (op == rlr_pkg::OP_D_SQ || op == rlr_pkg::OP_N_SQ ||
                 op == rlr_pkg::OP_T);
    end
  end

  assign add_res = {1'b0, add_a} + {1'b0, add_b ^ {64{add_sub}}} + 65'(add_sub);

  // division setup
  assign num_mag   = acc[63] ? 64'(-acc) : 64'(acc);
  assign d_mag     = d_reg[63] ? 64'(-d_reg) : 64'(d_reg);
  assign den_sel   = frac_mode ? d_mag : {48'b0, count};
  assign spread_ok = d_mag > {2'b0, min_spread};
  assign ovf_now   = {32'b0, num_mag[63:32]} >= den_sel;

  // rounding (ties away from zero on the magnitude) and saturation
  assign round_up = {rem, 1'b0} >= {1'b0, den};
  assign q_round  = {1'b0, quo} + (DIV_W + 1)'(round_up);
  assign big      = ovf || (|q_round[DIV_W:31]);
  always_comb begin
    if (big) begin
      div_res = neg ? rlr_pkg::SAT_NEG : rlr_pkg::SAT_POS;
    end else begin
      div_res = neg ? 32'(-q_round[31:0]) : q_round[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rlr_pkg::S_IDLE: begin
        if (accept) state_next = rlr_pkg::S_MUL;
      end
      rlr_pkg::S_MUL: state_next = rlr_pkg::S_ACC;
      rlr_pkg::S_ACC: begin
        if (op == rlr_pkg::OP_N_SQ || op == rlr_pkg::OP_T) begin
          state_next = rlr_pkg::S_SETUP;
        end else begin
          state_next = rlr_pkg::S_MUL;
        end
      end
      rlr_pkg::S_SETUP: begin
        if (frac_mode && !spread_ok) begin
          state_next = rlr_pkg::S_DONE;
        end else if (ovf_now) begin
          state_next = rlr_pkg::S_ROUND;
        end else begin
          state_next = rlr_pkg::S_DIV;
        end
      end
      rlr_pkg::S_DIV: begin
        if (iter == ITER_W'(1)) state_next = rlr_pkg::S_ROUND;
      end
      rlr_pkg::S_ROUND: begin
        state_next = frac_mode ? rlr_pkg::S_MUL : rlr_pkg::S_DONE;
      end
      rlr_pkg::S_DONE: begin
        if (out_free) state_next = rlr_pkg::S_IDLE;
      end
      default: state_next = rlr_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready = (state == rlr_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rlr_pkg::S_IDLE;
      op         <= rlr_pkg::OP_XX;
      count      <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_xx     <= '0;
      sum_xy     <= '0;
      min_spread <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (min_spread_we) min_spread <= min_spread_wdata;

      if (state == rlr_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        rlr_pkg::S_IDLE: begin
          if (accept) begin
            if (s_tuser) begin
              count     <= '0;
              sum_x     <= '0;
              sum_y     <= '0;
              sum_xx    <= '0;
              sum_xy    <= '0;
              full_flag <= 1'b0;
              op        <= rlr_pkg::OP_D_LO;
            end else if (count >= rlr_pkg::COUNT_W'(MAX_SAMPLES)) begin
              full_flag <= 1'b1;
              op        <= rlr_pkg::OP_D_LO;
            end else begin
              count     <= count + 16'd1;
              sum_x     <= sum_x + 32'(x_in);
              sum_y     <= sum_y + 32'(y_in);
              full_flag <= 1'b0;
              op        <= rlr_pkg::OP_XX;
            end
          end
        end
        rlr_pkg::S_ACC: begin
          case (op)
            rlr_pkg::OP_XX: sum_xx <= sum_xx + prod[46:0];
            rlr_pkg::OP_XY: sum_xy <= sum_xy + prod[47:0];
            default: ;
          endcase
          op <= rlr_pkg::op_t'(op + 4'd1);
        end
        rlr_pkg::S_ROUND: begin
          if (frac_mode) op <= rlr_pkg::OP_T;
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    if (accept) begin
      x_reg <= x_in;
      y_reg <= y_in;
    end
    case (state)
      rlr_pkg::S_MUL: prod <= mul_a * mul_b;
      rlr_pkg::S_ACC: begin
        if (op != rlr_pkg::OP_XX && op != rlr_pkg::OP_XY) acc <= add_res[63:0];
        if (op == rlr_pkg::OP_D_SQ) d_reg <= add_res[63:0];
        frac_mode <= (op == rlr_pkg::OP_N_SQ);
      end
      rlr_pkg::S_SETUP: begin
        rem   <= {32'b0, num_mag[63:32]};
        den   <= den_sel;
        shreg <= {num_mag[31:0], {FRAC_BITS{1'b0}}};
        quo   <= '0;
        iter  <= frac_mode ? ITER_W'(DIV_W) : ITER_W'(32);
        neg   <= acc[63] ^ (frac_mode & d_reg[63]);
        ovf   <= ovf_now;
        if (frac_mode) begin
          fit_valid <= spread_ok;
          if (!spread_ok) begin
            slope <= '0;
            icpt  <= '0;
          end
        end
      end
      rlr_pkg::S_DIV: begin
        rem   <= add_res[64] ? add_res[63:0] : rem_sh;
        quo   <= {quo[DIV_W-2:0], add_res[64]};
        shreg <= shreg << 1;
        iter  <= iter - ITER_W'(1);
      end
      rlr_pkg::S_ROUND: begin
        if (frac_mode) begin
          slope <= div_res;
        end else begin
          icpt <= div_res;
        end
      end
      rlr_pkg::S_DONE: begin
        if (out_free) begin
          m_tdata <= {6'b0, full_flag, icpt, slope, fit_valid, count};
        end
      end
      default: ;
    endcase
  end

  `RLR_ASSERT_IMP(a_count_cap, 1'b1, count <= 16'(MAX_SAMPLES), "count above limit")
  `RLR_ASSERT_IMP(a_invalid_zero, m_tvalid && !m_tdata[16], m_tdata[80:17] == '0, "invalid fit not zero")
  `RLR_ASSERT_IMP(a_full_at_cap, m_tvalid && m_tdata[81], m_tdata[15:0] == 16'(MAX_SAMPLES), "drop below cap")
  `RLR_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready during work")

endmodule

FILE: tb/sv/rlr_checker.sv
// ----------------------------------------------------------------------------
// rlr_checker
// Watches the line fit channels, predicts each result word and compares.
// ----------------------------------------------------------------------------
module rlr_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // x_sample[15:0], y_sample[31:16]
  input  logic        s_tuser,   // action
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,   // sample_count, fit_valid, slope, intercept, count_full
  input  logic        min_spread_we,
  input  logic [61:0] min_spread_wdata,
  output int          fail_count,
  output int          pending_fits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_N = rlr_pkg::MAX_SAMPLES_DEF;
  localparam int FRAC  = rlr_pkg::FRAC_BITS_DEF;

  // listed from the top bit down, so sample_count lands in the low bits
  typedef struct packed {
    logic        count_full;
    logic [31:0] intercept;
    logic [31:0] slope;
    logic        fit_valid;
    logic [15:0] sample_count;
  } fit_t;

  fit_t        fit_q[$];
  logic [61:0] spread_lim;
  int          n_acc;
  longint      acc_x, acc_y, acc_xx, acc_xy;

  function automatic logic [31:0] sat32(bit neg, logic [63:0] m);
    if (neg) return (m >= 64'h8000_0000) ? rlr_pkg::SAT_NEG : 32'(-m);
    return (m > 64'h7FFF_FFFF) ? rlr_pkg::SAT_POS : m[31:0];
  endfunction

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // round(num * 2^FRAC / den), ties away from zero
  function automatic logic [31:0] slope_div(bit neg, logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    if (q >= 64'h1_0000_0000) return sat32(neg, q);
    for (int i = 0; i < FRAC; i++) begin
      q = q << 1;
      if (r >= den - r) begin
        q = q | 64'd1;
        r = r - (den - r);
      end else begin
        r = r << 1;
      end
    end
    if (r >= den - r) q = q + 1;
    return sat32(neg, q);
  endfunction

  function automatic fit_t next_fit(bit clr, logic [15:0] xs, logic [15:0] ys);
    fit_t   f;
    longint n, d, nm, t, x, y;
    logic [63:0] dm, r, q;
    f = '0;
    if (clr) begin
      n_acc = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
    end else if (n_acc >= MAX_N) begin
      f.count_full = 1'b1;
    end else begin
      x = longint'($signed(xs));
      y = longint'($signed(ys));
      n_acc++;
      acc_x += x; acc_y += y; acc_xx += x * x; acc_xy += x * y;
    end
    f.sample_count = n_acc[15:0];
    if (n_acc > 0) begin
      n  = n_acc;
      d  = n * acc_xx - acc_x * acc_x;
      dm = mag(d);
      if (dm > {2'b00, spread_lim}) begin
        nm = n * acc_xy - acc_x * acc_y;
        f.fit_valid = 1'b1;
        f.slope = slope_div((nm < 0) != (d < 0), mag(nm), dm);
        t = acc_y * (longint'(1) << FRAC) - longint'($signed(f.slope)) * acc_x;
        q = mag(t) / 64'(n);
        r = mag(t) % 64'(n);
        if (r >= 64'(n) - r) q = q + 1;
        f.intercept = sat32(t < 0, q);
      end
    end
    return f;
  endfunction

  always @(posedge clk) begin
    fit_t got, want;
    if (rst) begin
      fit_q.delete();
      spread_lim <= '0;
      fail_count = 0;
      n_acc = 0; acc_x = 0; acc_y = 0; acc_xx = 0; acc_xy = 0;
    end else begin
      if (min_spread_we) spread_lim <= min_spread_wdata;
      if (s_tvalid && s_tready)
        fit_q.push_back(next_fit(s_tuser, s_tdata[15:0], s_tdata[31:16]));
      if (m_tvalid && m_tready) begin
        got = fit_t'(m_tdata[81:0]);
        if (fit_q.size() == 0) begin
          $error("unexpected result word %h", m_tdata);
          fail_count++;
        end else begin
          want = fit_q.pop_front();
          if (got.sample_count !== want.sample_count) begin
            $error("sample_count: expected %0d, got %0d", want.sample_count,
                   got.sample_count);
            fail_count++;
          end
          if (got.fit_valid !== want.fit_valid) begin
            $error("fit_valid: expected %0d, got %0d", want.fit_valid, got.fit_valid);
            fail_count++;
          end
          if (got.slope !== want.slope) begin
            $error("slope: expected %h, got %h", want.slope, got.slope);
            fail_count++;
          end
          if (got.intercept !== want.intercept) begin
            $error("intercept: expected %h, got %h", want.intercept, got.intercept);
            fail_count++;
          end
          if (got.count_full !== want.count_full) begin
            $error("count_full: expected %0d, got %0d", want.count_full,
                   got.count_full);
            fail_count++;
          end
        end
      end
    end
    pending_fits <= fit_q.size();
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the running line fit block.
// ----------------------------------------------------------------------------
// Directed words (extremes, clear, degenerate spread, saturation) then random
// sample runs under several spread thresholds, with bursty input and a
// stalling receiver. Checking is done in rlr_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit ADD = 1'b0;
  localparam bit CLR = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;
  logic        min_spread_we = 1'b0;
  logic [61:0] min_spread_wdata = '0;
  int          fail_count, pending_fits;
  int          burst_left = 0;
  int          stall_mode = 0;

  always #10 clk = ~clk;

  running_linear_regression_top i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .min_spread_we, .min_spread_wdata
  );

  rlr_checker i_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .min_spread_we, .min_spread_wdata,
    .fail_count, .pending_fits
  );

  // receiver: stall pattern changes every so often
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_word(bit act, logic [15:0] x, logic [15:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 150);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {y, x};
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending_fits == 0) break;
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic set_spread(logic [61:0] v);
    drain();
    min_spread_we    <= 1'b1;
    min_spread_wdata <= v;
    @(posedge clk);
    min_spread_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n_words, int x_span);
    logic [15:0] x, y;
    for (int i = 0; i < n_words; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_word(CLR, 16'($urandom), 16'($urandom));
      end else begin
        x = (x_span == 0) ? 16'($urandom) : 16'($urandom_range(0, x_span) - x_span / 2);
        y = 16'($urandom);
        send_word(ADD, x, y);
      end
    end
  endtask

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_word(ADD, 16'h8000, 16'h8000);
    send_word(ADD, 16'h8000, 16'h7FFF);   // same x twice: zero spread
    send_word(ADD, 16'h7FFF, 16'h7FFF);
    send_word(ADD, 16'h0000, 16'hFFFF);
    send_word(CLR, 16'hFFFF, 16'hFFFF);
    send_word(ADD, 16'h0000, 16'h8000);   // steep pair: slope saturates high
    send_word(ADD, 16'h0001, 16'h7FFF);
    send_word(CLR, 16'h0000, 16'h0000);
    send_word(ADD, 16'h0000, 16'h7FFF);   // steep falling run: negative slope
    send_word(ADD, 16'h0001, 16'h8000);
    send_word(ADD, 16'h0002, 16'h0000);
    send_word(CLR, 16'h0000, 16'h0000);
    send_word(ADD, 16'h0003, 16'h0007);
    send_word(ADD, 16'hFFFD, 16'hFFF9);
    send_word(ADD, 16'h0005, 16'h0002);
    set_spread(62'h3FFF_FFFF_FFFF_FFFF);
    send_word(ADD, 16'h1234, 16'h4321);
    send_word(ADD, 16'hABCD, 16'h0F0F);
    set_spread(62'd100);
    send_word(ADD, 16'h0001, 16'h0002);
    send_word(CLR, 16'h0000, 16'h0000);

    // random
    set_spread(62'd0);
    random_phase(300, 0);
    set_spread(62'($urandom_range(1, 1 << 20)));
    random_phase(200, 64);
    set_spread({30'($urandom), 32'($urandom)} >> 20);
    random_phase(200, 0);
    set_spread(62'd0);
    random_phase(150, 6);
    set_spread(62'h3FFF_FFFF_FFFF_FFFF);
    random_phase(50, 0);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
